// ----- hdl/contiguous_first_fit_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the contiguous first-fit allocator
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cffa_pkg.sv -----
// ----------------------------------------------------------------------------
// cffa_pkg
// Types, widths and codes shared by the contiguous first-fit allocator.
// ----------------------------------------------------------------------------
package cffa_pkg;

  localparam int unsigned CELLS_DEF = 64;
  localparam int unsigned OWNER_W   = 8;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned BASE_W    = 6;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic               command;
    logic [OWNER_W-1:0] owner_id;
    logic [LEN_W-1:0]   run_length;
  } in_t;

  typedef struct packed {
    logic              success;
    logic [BASE_W-1:0] base_index;
    logic              compacted;
  } out_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LOAD,
    DP_ASCAN,
    DP_CINIT,
    DP_CSCAN,
    DP_FINIT_RUN,
    DP_FINIT_CMP,
    DP_FILL,
    DP_FSCAN
  } dp_op_t;

  typedef struct packed {
    logic found;
    logic scan_done;
    logic enough;
    logic fill_last;
    logic clear_last;
    out_t res;
  } dp_status_t;

endpackage

// ----- hdl/cffa_ram.sv -----
// ----------------------------------------------------------------------------
// cffa_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module cffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/cffa_dpath.sv -----
// ----------------------------------------------------------------------------
// cffa_dpath
// Cell store, scan counters and run bookkeeping of the allocator.
// ----------------------------------------------------------------------------
module cffa_dpath #(
  parameter int unsigned CELLS = cffa_pkg::CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cffa_pkg::in_t        in_data,
  input  cffa_pkg::dp_op_t     dp_cmd,
  output cffa_pkg::dp_status_t dp_st
);

  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);
  localparam int unsigned CMP_W  = (CNT_W > cffa_pkg::LEN_W) ? CNT_W : cffa_pkg::LEN_W;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CELLS - 1);

  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] proc_idx_r, proc_idx_nxt;
  logic              proc_v_r, proc_v_nxt;
  logic [CNT_W-1:0]  run_len_r, run_len_nxt;
  logic [ADDR_W-1:0] run_start_r, run_start_nxt;
  logic [CNT_W-1:0]  total_free_r, total_free_nxt;
  logic              found_r, found_nxt;
  logic              scan_done_r, scan_done_nxt;
  logic [CNT_W-1:0]  cleared_r, cleared_nxt;
  logic [CNT_W-1:0]  dst_r, dst_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic              ok_r, ok_nxt;
  logic              cmp_r, cmp_nxt;
  logic              free_cmd_r, free_cmd_nxt;
  logic [cffa_pkg::OWNER_W-1:0] owner_r, owner_nxt;
  logic [cffa_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [CNT_W-1:0]  fill_k_r, fill_k_nxt;
  logic [CNT_W-1:0]  fill_total_r, fill_total_nxt;

  logic                         we;
  logic [ADDR_W-1:0]            wr_addr;
  logic [cffa_pkg::OWNER_W-1:0] wr_data;
  logic [cffa_pkg::OWNER_W-1:0] rd_data;
  logic [CNT_W-1:0]             run_inc;
  logic [CNT_W-1:0]             dst_dec;
  logic [ADDR_W-1:0]            addr_up;
  logic [ADDR_W-1:0]            addr_down;

  cffa_ram #(
    .WIDTH (cffa_pkg::OWNER_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign run_inc   = run_len_r + CNT_W'(1);
  assign dst_dec   = dst_r - CNT_W'(1);
  assign addr_up   = (addr_r == LAST_IDX) ? '0 : addr_r + ADDR_W'(1);
  assign addr_down = (addr_r == '0) ? LAST_IDX : addr_r - ADDR_W'(1);

  always_comb begin
    we             = 1'b0;
    wr_addr        = addr_r;
    wr_data        = '0;
    addr_nxt       = addr_r;
    proc_idx_nxt   = proc_idx_r;
    proc_v_nxt     = proc_v_r;
    run_len_nxt    = run_len_r;
    run_start_nxt  = run_start_r;
    total_free_nxt = total_free_r;
    found_nxt      = found_r;
    scan_done_nxt  = scan_done_r;
    cleared_nxt    = cleared_r;
    dst_nxt        = dst_r;
    base_nxt       = base_r;
    ok_nxt         = ok_r;
    cmp_nxt        = cmp_r;
    free_cmd_nxt   = free_cmd_r;
    owner_nxt      = owner_r;
    len_nxt        = len_r;
    fill_k_nxt     = fill_k_r;
    fill_total_nxt = fill_total_r;
    unique case (dp_cmd)
      cffa_pkg::DP_NOP: begin
      end
      cffa_pkg::DP_CLEAR: begin
        we       = 1'b1;
        wr_addr  = addr_r;
        wr_data  = '0;
        addr_nxt = addr_up;
      end
      cffa_pkg::DP_LOAD: begin
        owner_nxt      = in_data.owner_id;
        len_nxt        = in_data.run_length;
        free_cmd_nxt   = (in_data.command == cffa_pkg::CMD_FREE);
        addr_nxt       = '0;
        proc_v_nxt     = 1'b0;
        run_len_nxt    = '0;
        run_start_nxt  = '0;
        total_free_nxt = '0;
        found_nxt      = 1'b0;
        scan_done_nxt  = 1'b0;
        cleared_nxt    = '0;
        base_nxt       = '0;
        ok_nxt         = 1'b0;
        cmp_nxt        = 1'b0;
      end
      cffa_pkg::DP_ASCAN: begin
        addr_nxt     = addr_up;
        proc_v_nxt   = 1'b1;
        proc_idx_nxt = addr_r;
        if (proc_v_r && !found_r && !scan_done_r) begin
          if (rd_data == '0) begin
            run_len_nxt    = run_inc;
            total_free_nxt = total_free_r + CNT_W'(1);
            if (run_len_r == '0) begin
              run_start_nxt = proc_idx_r;
            end
            if (CMP_W'(run_inc) >= CMP_W'(len_r)) begin
              found_nxt = 1'b1;
              base_nxt  = (run_len_r == '0) ? proc_idx_r : run_start_r;
            end
          end else begin
            run_len_nxt = '0;
          end
          if (proc_idx_r == LAST_IDX) begin
            scan_done_nxt = 1'b1;
          end
        end
      end
      cffa_pkg::DP_CINIT: begin
        addr_nxt      = LAST_IDX;
        proc_v_nxt    = 1'b0;
        scan_done_nxt = 1'b0;
        dst_nxt       = CNT_W'(CELLS);
      end
      cffa_pkg::DP_CSCAN: begin
        addr_nxt     = addr_down;
        proc_v_nxt   = 1'b1;
        proc_idx_nxt = addr_r;
        if (proc_v_r && !scan_done_r) begin
          if (rd_data != '0) begin
            we      = 1'b1;
            wr_addr = ADDR_W'(dst_dec);
            wr_data = rd_data;
            dst_nxt = dst_dec;
          end
          if (proc_idx_r == '0) begin
            scan_done_nxt = 1'b1;
          end
        end
      end
      cffa_pkg::DP_FINIT_RUN: begin
        fill_k_nxt     = '0;
        fill_total_nxt = CNT_W'(len_r);
        ok_nxt         = 1'b1;
      end
      cffa_pkg::DP_FINIT_CMP: begin
        fill_k_nxt     = '0;
        fill_total_nxt = total_free_r;
        base_nxt       = '0;
        ok_nxt         = 1'b1;
        cmp_nxt        = 1'b1;
      end
      cffa_pkg::DP_FILL: begin
        we         = 1'b1;
        wr_addr    = ADDR_W'(CNT_W'(base_r) + fill_k_r);
        wr_data    = (CMP_W'(fill_k_r) < CMP_W'(len_r)) ? owner_r : '0;
        fill_k_nxt = fill_k_r + CNT_W'(1);
      end
      cffa_pkg::DP_FSCAN: begin
        addr_nxt     = addr_up;
        proc_v_nxt   = 1'b1;
        proc_idx_nxt = addr_r;
        if (proc_v_r && !scan_done_r) begin
          if ((rd_data == owner_r) && (CMP_W'(cleared_r) < CMP_W'(len_r))) begin
            we          = 1'b1;
            wr_addr     = proc_idx_r;
            wr_data     = '0;
            cleared_nxt = cleared_r + CNT_W'(1);
          end
          if (proc_idx_r == LAST_IDX) begin
            scan_done_nxt = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      proc_v_r <= 1'b0;
    end else begin
      addr_r   <= addr_nxt;
      proc_v_r <= proc_v_nxt;
    end
    proc_idx_r   <= proc_idx_nxt;
    run_len_r    <= run_len_nxt;
    run_start_r  <= run_start_nxt;
    total_free_r <= total_free_nxt;
    found_r      <= found_nxt;
    scan_done_r  <= scan_done_nxt;
    cleared_r    <= cleared_nxt;
    dst_r        <= dst_nxt;
    base_r       <= base_nxt;
    ok_r         <= ok_nxt;
    cmp_r        <= cmp_nxt;
    free_cmd_r   <= free_cmd_nxt;
    owner_r      <= owner_nxt;
    len_r        <= len_nxt;
    fill_k_r     <= fill_k_nxt;
    fill_total_r <= fill_total_nxt;
  end

  always_comb begin
    dp_st.found      = found_r;
    dp_st.scan_done  = scan_done_r;
    dp_st.enough     = (CMP_W'(total_free_r) >= CMP_W'(len_r));
    dp_st.fill_last  = (fill_k_r == fill_total_r - CNT_W'(1));
    dp_st.clear_last = (addr_r == LAST_IDX);
    if (free_cmd_r) begin
      dp_st.res.success    = (CMP_W'(cleared_r) == CMP_W'(len_r));
      dp_st.res.base_index = '0;
      dp_st.res.compacted  = 1'b0;
    end else begin
      dp_st.res.success    = ok_r || (len_r == '0);
      dp_st.res.base_index = ok_r ? cffa_pkg::BASE_W'(base_r) : '0;
      dp_st.res.compacted  = cmp_r;
    end
  end

endmodule

// ----- hdl/cffa_ctrl.sv -----
// ----------------------------------------------------------------------------
// cffa_ctrl
// Command sequencer of the allocator and the result register.
// ----------------------------------------------------------------------------
module cffa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cffa_pkg::in_t        in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cffa_pkg::out_t       out_data,
  output cffa_pkg::dp_op_t     dp_cmd,
  input  cffa_pkg::dp_status_t dp_st
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ASCAN,
    S_CSCAN,
    S_FILL,
    S_FSCAN,
    S_DONE
  } state_t;

  state_t         state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;
  cffa_pkg::out_t out_data_r, out_data_nxt;

  always_comb begin
    state_nxt     = state_r;
    dp_cmd        = cffa_pkg::DP_NOP;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_CLEAR: begin
        dp_cmd = cffa_pkg::DP_CLEAR;
        if (dp_st.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd = cffa_pkg::DP_LOAD;
          if (in_data.command == cffa_pkg::CMD_FREE) begin
            state_nxt = S_FSCAN;
          end else if (in_data.run_length == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_ASCAN;
          end
        end
      end
      S_ASCAN: begin
        if (dp_st.found) begin
          dp_cmd    = cffa_pkg::DP_FINIT_RUN;
          state_nxt = S_FILL;
        end else if (dp_st.scan_done) begin
          if (dp_st.enough) begin
            dp_cmd    = cffa_pkg::DP_CINIT;
            state_nxt = S_CSCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          dp_cmd = cffa_pkg::DP_ASCAN;
        end
      end
      S_CSCAN: begin
        if (dp_st.scan_done) begin
          dp_cmd    = cffa_pkg::DP_FINIT_CMP;
          state_nxt = S_FILL;
        end else begin
          dp_cmd = cffa_pkg::DP_CSCAN;
        end
      end
      S_FILL: begin
        dp_cmd = cffa_pkg::DP_FILL;
        if (dp_st.fill_last) begin
          state_nxt = S_DONE;
        end
      end
      S_FSCAN: begin
        if (dp_st.scan_done) begin
          state_nxt = S_DONE;
        end else begin
          dp_cmd = cffa_pkg::DP_FSCAN;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = dp_st.res;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/contiguous_first_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_first_fit_allocator
// First-fit allocator of contiguous cell runs with compaction on demand.
//
//   Channel   Ports                          Carries
//   input     in_valid, in_ready, in_data    command, owner_id, run_length
//   result    out_valid, out_ready, out_data success, base_index, compacted
//
// A free scans the whole store once; an allocation runs the first-fit scan,
// a compaction scan when it has to compact, and then writes one cell at a
// time, which after a compaction covers every free cell.
// After reset the store is cleared cell by cell before in_ready rises.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken.
// ----------------------------------------------------------------------------
`include "contiguous_first_fit_allocator_assert.svh"

module contiguous_first_fit_allocator #(
  parameter int unsigned CELLS = cffa_pkg::CELLS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cffa_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cffa_pkg::out_t out_data
);

  cffa_pkg::dp_op_t     dp_cmd;
  cffa_pkg::dp_status_t dp_st;
  logic                 in_take;
  logic                 zero_alloc;
  logic                 cmp_start;

  cffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .dp_cmd    (dp_cmd),
    .dp_st     (dp_st)
  );

  cffa_dpath #(
    .CELLS (CELLS)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .dp_cmd  (dp_cmd),
    .dp_st   (dp_st)
  );

  assign in_take    = in_valid && in_ready;
  assign zero_alloc = in_take && (in_data.command == cffa_pkg::CMD_ALLOC)
                      && (in_data.run_length == '0);
  assign cmp_start  = (dp_cmd == cffa_pkg::DP_FINIT_CMP);

  `CFFA_ASSERT_NEXT(a_busy_after_accept, in_take, !in_ready, "item taken while busy")
  `CFFA_ASSERT_SAME(a_compact_needs_room, cmp_start, dp_st.enough, "compaction without room")
  `CFFA_ASSERT_NEXT(a_zero_alloc_ok, zero_alloc, dp_st.res.success, "empty allocation failed")

endmodule

// ----- tb/tb_contiguous_first_fit_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_first_fit_allocator
// Self-checking testbench for the contiguous first-fit allocator. A short
// table of directed commands covers the empty and full store, zero-length
// and oversized requests, owner 0, compaction and partial frees; a long
// random run of allocate and free commands from a small set of owners
// follows. Each result item is checked against its table row, if given, or
// a cell-level store copy in the testbench; both channels idle at random.
// ----------------------------------------------------------------------------
module tb_contiguous_first_fit_allocator;

  localparam int CELLS     = cffa_pkg::CELLS_DEF;
  localparam int RANDOM_N  = 2000;
  localparam int QUIET_AT  = 1700;
  localparam int DRAIN_CYC = 250;
  localparam int PLAN_N    = 26;

  typedef struct {
    cffa_pkg::in_t  item;
    bit             typed;
    cffa_pkg::out_t exp;
  } row_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  cffa_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  cffa_pkg::out_t out_data;

  logic [cffa_pkg::OWNER_W-1:0] cell_tag [CELLS];
  cffa_pkg::out_t pending_grants[$];
  cffa_pkg::out_t predicted;
  bit             row_typed;
  cffa_pkg::out_t row_exp;
  int             idle_pct;
  int             stall_left;
  int             mismatches;

  contiguous_first_fit_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Applies one command to the local copy of the store and returns its result.
  function automatic cffa_pkg::out_t next_grant(cffa_pkg::in_t c);
    cffa_pkg::out_t               r;
    int                           len;
    int                           i;
    int                           run_start;
    int                           run_len;
    int                           total_free;
    int                           cleared;
    int                           dst;
    int                           base;
    bit                           found;
    logic [cffa_pkg::OWNER_W-1:0] v;
    r          = '0;
    len        = c.run_length;
    run_start  = 0;
    run_len    = 0;
    total_free = 0;
    cleared    = 0;
    base       = 0;
    found      = 1'b0;
    if (c.command == cffa_pkg::CMD_FREE) begin
      for (i = 0; i < CELLS && cleared < len; i++) begin
        if (cell_tag[i] == c.owner_id) begin
          cell_tag[i] = '0;
          cleared++;
        end
      end
      r.success = (cleared == len);
      return r;
    end
    if (len == 0) begin
      r.success = 1'b1;
      return r;
    end
    for (i = 0; i < CELLS && !found; i++) begin
      if (cell_tag[i] == '0) begin
        if (run_len == 0) begin
          run_start = i;
        end
        run_len++;
        total_free++;
      end else begin
        run_len = 0;
      end
      if (run_len >= len) begin
        found = 1'b1;
        base  = run_start;
      end
    end
    if (!found) begin
      for (; i < CELLS; i++) begin
        if (cell_tag[i] == '0) begin
          total_free++;
        end
      end
      if (total_free < len) begin
        return r;
      end
      dst = CELLS;
      for (i = CELLS - 1; i >= 0; i--) begin
        if (cell_tag[i] != '0) begin
          v = cell_tag[i];
          dst--;
          cell_tag[i]   = '0;
          cell_tag[dst] = v;
        end
      end
      base        = 0;
      r.compacted = 1'b1;
    end
    for (i = 0; i < len; i++) begin
      cell_tag[base + i] = c.owner_id;
    end
    r.success    = 1'b1;
    r.base_index = base[cffa_pkg::BASE_W-1:0];
    return r;
  endfunction

  function automatic row_t mk(logic cmd, int own, int len, bit typed, logic ok, int base,
                              logic comp);
    row_t r;
    r.item.command     = cmd;
    r.item.owner_id    = own[cffa_pkg::OWNER_W-1:0];
    r.item.run_length  = len[cffa_pkg::LEN_W-1:0];
    r.typed            = typed;
    r.exp.success      = ok;
    r.exp.base_index   = base[cffa_pkg::BASE_W-1:0];
    r.exp.compacted    = comp;
    return r;
  endfunction

  function automatic void check_field(string name, int exp, int got);
    if (exp != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, got);
      mismatches++;
    end
  endfunction

  task automatic pause_slot();
    @(negedge clk);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic offer(cffa_pkg::in_t item, bit typed, cffa_pkg::out_t exp);
    in_data   <= item;
    row_typed <= typed;
    row_exp   <= exp;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predicted = next_grant(in_data);
      pending_grants.insert(pending_grants.size(), row_typed ? row_exp : predicted);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result item %p", $time, out_data);
        mismatches++;
      end else begin
        check_field("success", pending_grants[0].success, out_data.success);
        check_field("base_index", pending_grants[0].base_index, out_data.base_index);
        check_field("compacted", pending_grants[0].compacted, out_data.compacted);
        void'(pending_grants.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 16) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    #20_000_000;
    $display("contiguous_first_fit_allocator regression: fail");
    $finish;
  end

  initial begin
    row_t          plan [PLAN_N];
    cffa_pkg::in_t item;
    int            k;
    int            i;
    int            pick;
    int            own;
    int            held;
    int            len;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    row_typed  = 1'b0;
    row_exp    = '0;
    idle_pct   = 20;
    stall_left = 0;
    mismatches = 0;
    foreach (cell_tag[i]) begin
      cell_tag[i] = '0;
    end

    plan[0]  = mk(cffa_pkg::CMD_ALLOC,   1,   0, 1, 1'b1, 0, 1'b0);
    plan[1]  = mk(cffa_pkg::CMD_ALLOC, 255, 127, 1, 1'b0, 0, 1'b0);
    plan[2]  = mk(cffa_pkg::CMD_ALLOC,   1,  64, 1, 1'b1, 0, 1'b0);
    plan[3]  = mk(cffa_pkg::CMD_ALLOC,   2,   1, 1, 1'b0, 0, 1'b0);
    plan[4]  = mk(cffa_pkg::CMD_FREE,    1,   0, 1, 1'b1, 0, 1'b0);
    plan[5]  = mk(cffa_pkg::CMD_FREE,    2,   1, 1, 1'b0, 0, 1'b0);
    plan[6]  = mk(cffa_pkg::CMD_FREE,    1,  64, 1, 1'b1, 0, 1'b0);
    plan[7]  = mk(cffa_pkg::CMD_FREE,    0,  64, 1, 1'b1, 0, 1'b0);
    plan[8]  = mk(cffa_pkg::CMD_FREE,    0,  65, 1, 1'b0, 0, 1'b0);
    plan[9]  = mk(cffa_pkg::CMD_ALLOC,   0,   5, 0, 1'b0, 0, 1'b0);
    plan[10] = mk(cffa_pkg::CMD_ALLOC,   3,  10, 0, 1'b0, 0, 1'b0);
    plan[11] = mk(cffa_pkg::CMD_ALLOC,   4,  20, 0, 1'b0, 0, 1'b0);
    plan[12] = mk(cffa_pkg::CMD_ALLOC,   5,  10, 0, 1'b0, 0, 1'b0);
    plan[13] = mk(cffa_pkg::CMD_FREE,    4,  20, 0, 1'b0, 0, 1'b0);
    plan[14] = mk(cffa_pkg::CMD_ALLOC,   6,  30, 0, 1'b0, 0, 1'b0);
    plan[15] = mk(cffa_pkg::CMD_FREE,    3,  15, 0, 1'b0, 0, 1'b0);
    plan[16] = mk(cffa_pkg::CMD_ALLOC,   7,  64, 0, 1'b0, 0, 1'b0);
    plan[17] = mk(cffa_pkg::CMD_ALLOC, 170,  42, 0, 1'b0, 0, 1'b0);
    plan[18] = mk(cffa_pkg::CMD_FREE,    6,  30, 0, 1'b0, 0, 1'b0);
    plan[19] = mk(cffa_pkg::CMD_FREE,    5,  10, 0, 1'b0, 0, 1'b0);
    plan[20] = mk(cffa_pkg::CMD_ALLOC, 170,  42, 0, 1'b0, 0, 1'b0);
    plan[21] = mk(cffa_pkg::CMD_ALLOC,  85,  21, 0, 1'b0, 0, 1'b0);
    plan[22] = mk(cffa_pkg::CMD_ALLOC, 128,   1, 0, 1'b0, 0, 1'b0);
    plan[23] = mk(cffa_pkg::CMD_FREE,  255, 127, 1, 1'b0, 0, 1'b0);
    plan[24] = mk(cffa_pkg::CMD_FREE,  170,  42, 0, 1'b0, 0, 1'b0);
    plan[25] = mk(cffa_pkg::CMD_FREE,   85,  21, 0, 1'b0, 0, 1'b0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      pause_slot();
      offer(plan[k].item, plan[k].typed, plan[k].exp);
    end

    for (k = 0; k < RANDOM_N; k++) begin
      if (k % 250 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 50;
        endcase
      end
      if (k >= QUIET_AT) begin
        idle_pct = 0;
      end
      pause_slot();
      pick = $urandom_range(0, 99);
      own  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 7);
      if (pick < 50) begin
        item.command = cffa_pkg::CMD_ALLOC;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          len = $urandom_range(1, 12);
        end else if (pick < 95) begin
          len = $urandom_range(13, 40);
        end else begin
          len = $urandom_range(41, 64);
        end
      end else if (pick < 85) begin
        item.command = cffa_pkg::CMD_FREE;
        held = 0;
        for (i = 0; i < CELLS; i++) begin
          if (cell_tag[i] == own[cffa_pkg::OWNER_W-1:0]) begin
            held++;
          end
        end
        len = ($urandom_range(0, 4) != 0) ? held : $urandom_range(0, held + 2);
      end else begin
        item.command = $urandom_range(0, 1) ? cffa_pkg::CMD_FREE : cffa_pkg::CMD_ALLOC;
        own = $urandom_range(0, 255);
        len = $urandom_range(0, 127);
      end
      item.owner_id   = own[cffa_pkg::OWNER_W-1:0];
      item.run_length = len[cffa_pkg::LEN_W-1:0];
      offer(item, 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("contiguous_first_fit_allocator regression: pass");
    end else begin
      $display("contiguous_first_fit_allocator regression: fail");
    end
    $finish;
  end

endmodule
